// ===== rtl/lgw_pkg.sv =====
// shared types, codes and constants for the gradient wave block
`default_nettype none

package lgw_pkg;

  // zone and fixed-point geometry
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned PROG_W    = 21;
  localparam int unsigned GDIST_W   = 22;
  localparam int unsigned DIVD_W    = 24;
  localparam int unsigned DIVS_W    = 12;
  localparam int unsigned UPC_W     = 4;
  localparam int unsigned CNT_W     = 5;
  localparam logic [LEN_W-1:0] MAX_LEDS = 11'd1024;

  // configuration register indexes
  localparam logic [2:0] REG_START_COLOR = 3'd0;
  localparam logic [2:0] REG_END_COLOR   = 3'd1;
  localparam logic [2:0] REG_ZONE_LENGTH = 3'd2;
  localparam logic [2:0] REG_REVERSE     = 3'd3;
  localparam logic [2:0] REG_MATRIX_MODE = 3'd4;
  localparam logic [2:0] REG_SPEED       = 3'd5;
  localparam logic [2:0] REG_FRAME_RATE  = 3'd6;

  // input word opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // datapath action of one microcode step
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_WAIT,
    ACT_GFOLD,
    ACT_MUL,
    ACT_SUM,
    ACT_DLOAD_PIX,
    ACT_DLOAD_TICK,
    ACT_DSTEP,
    ACT_EMIT,
    ACT_PUPDATE
  } lgw_act_t;

  // next-address condition of one microcode step
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_TICK,
    JC_CNT_NZ,
    JC_WAIT_IN,
    JC_WAIT_OUT
  } lgw_jc_t;

  typedef struct packed {
    lgw_act_t         act;
    lgw_jc_t          jc;
    logic [UPC_W-1:0] target;
    logic [CNT_W-1:0] count;
  } lgw_uword_t;

  // control bundle from sequencer to datapath
  typedef struct packed {
    lgw_act_t act;
  } lgw_ctrl_t;

  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] position;
  } lgw_in_t;

  typedef struct packed {
    logic [POS_W-1:0] out_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } lgw_out_t;

endpackage

`default_nettype wire

// ===== rtl/lgw_useq.sv =====
// microcode sequencer: program rom, step counter and loop counter
`default_nettype none

module lgw_useq
  import lgw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      op_tick,
  input  wire logic      out_busy,
  output lgw_ctrl_t      ctrl
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  lgw_uword_t       uw;

  // program rom
  function automatic lgw_uword_t urom(input logic [UPC_W-1:0] a);
    lgw_uword_t w;
    begin
      w = '{act: ACT_NOP, jc: JC_ALWAYS, target: 4'd0, count: 5'd0};
      unique case (a)
        4'd0:  w = '{act: ACT_WAIT,       jc: JC_WAIT_IN,  target: 4'd1, count: 5'd0};
        4'd1:  w = '{act: ACT_GFOLD,      jc: JC_TICK,     target: 4'd8, count: 5'd0};
        4'd2:  w = '{act: ACT_MUL,        jc: JC_NEXT,     target: 4'd0, count: 5'd0};
        4'd3:  w = '{act: ACT_SUM,        jc: JC_NEXT,     target: 4'd0, count: 5'd0};
        4'd4:  w = '{act: ACT_DLOAD_PIX,  jc: JC_NEXT,     target: 4'd0, count: 5'd7};
        4'd5:  w = '{act: ACT_DSTEP,      jc: JC_CNT_NZ,   target: 4'd5, count: 5'd0};
        4'd6:  w = '{act: ACT_EMIT,       jc: JC_WAIT_OUT, target: 4'd0, count: 5'd0};
        4'd8:  w = '{act: ACT_DLOAD_TICK, jc: JC_NEXT,     target: 4'd0, count: 5'd23};
        4'd9:  w = '{act: ACT_DSTEP,      jc: JC_CNT_NZ,   target: 4'd9, count: 5'd0};
        4'd10: w = '{act: ACT_PUPDATE,    jc: JC_ALWAYS,   target: 4'd0, count: 5'd0};
        default: w = '{act: ACT_NOP,      jc: JC_ALWAYS,   target: 4'd0, count: 5'd0};
      endcase
      return w;
    end
  endfunction

  assign uw = urom(upc_r);

  // next address and loop counter
  always_comb begin
    upc_nxt = upc_r + 4'd1;
    cnt_nxt = cnt_r;
    unique case (uw.jc)
      JC_NEXT:     upc_nxt = upc_r + 4'd1;
      JC_ALWAYS:   upc_nxt = uw.target;
      JC_TICK:     upc_nxt = op_tick ? uw.target : upc_r + 4'd1;
      JC_CNT_NZ: begin
        if (cnt_r != '0) begin
          upc_nxt = uw.target;
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      JC_WAIT_IN:  upc_nxt = in_valid ? uw.target : upc_r;
      JC_WAIT_OUT: upc_nxt = out_busy ? upc_r : uw.target;
      default:     upc_nxt = '0;
    endcase
    if (uw.act == ACT_DLOAD_PIX || uw.act == ACT_DLOAD_TICK) begin
      cnt_nxt = uw.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= '0;
      cnt_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign ctrl.act = uw.act;

endmodule

`default_nettype wire

// ===== rtl/lgw_lane.sv =====
// one color channel: product, numerator and bit-serial restoring divider
`default_nettype none

module lgw_lane
  import lgw_pkg::*;
(
  input  wire logic               clk,
  input  wire lgw_ctrl_t          ctrl,
  input  wire logic [7:0]         start_ch,
  input  wire logic [7:0]         end_ch,
  input  wire logic [LEN_W-1:0]   len,
  input  wire logic [GDIST_W-1:0] gdist,
  input  wire logic [DIVD_W-1:0]  tick_dividend,
  input  wire logic [DIVS_W-1:0]  tick_divisor,
  output logic [DIVD_W-1:0]       quot,
  output logic [7:0]              chan
);

  logic signed [31:0]       prod_r, prod_nxt;
  logic [18:0]              base_r, base_nxt;
  logic signed [32:0]       num_r, num_nxt;
  logic [DIVS_W-1:0]        rem_r, rem_nxt;
  logic [DIVS_W-1:0]        div_r, div_nxt;
  logic [DIVD_W-1:0]        q_r, q_nxt;
  logic                     neg_r, neg_nxt;
  logic                     sat_r, sat_nxt;
  logic signed [8:0]        diff;
  logic [DIVD_W-1:0]        xnum;
  logic [DIVS_W:0]          trial;
  logic [DIVS_W:0]          trial_sub;
  logic                     trial_ge;

  assign diff      = $signed({1'b0, end_ch}) - $signed({1'b0, start_ch});
  assign xnum      = num_r[31:8];
  assign trial     = {rem_r, q_r[DIVD_W-1]};
  assign trial_ge  = trial >= {1'b0, div_r};
  assign trial_sub = trial - {1'b0, div_r};

  always_comb begin
    prod_nxt = prod_r;
    base_nxt = base_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    sat_nxt  = sat_r;
    unique case (ctrl.act)
      // distance times color delta, start color times length
      ACT_MUL: begin
        prod_nxt = $signed({1'b0, gdist}) * diff;
        base_nxt = start_ch * len;
      end
      // numerator in fixed point
      ACT_SUM: begin
        num_nxt = $signed({6'b0, base_r, 8'b0}) + $signed({prod_r[31], prod_r});
      end
      // pixel divide: top bits preloaded, quotient known to fit eight bits
      ACT_DLOAD_PIX: begin
        neg_nxt = num_r[32];
        sat_nxt = xnum >= {5'b0, len, 8'b0};
        rem_nxt = xnum[19:8];
        q_nxt   = {xnum[7:0], 16'b0};
        div_nxt = {1'b0, len};
      end
      // tick divide over the full dividend
      ACT_DLOAD_TICK: begin
        rem_nxt = '0;
        q_nxt   = tick_dividend;
        div_nxt = tick_divisor;
      end
      // one restoring step
      ACT_DSTEP: begin
        rem_nxt = trial_ge ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
        q_nxt   = {q_r[DIVD_W-2:0], trial_ge};
      end
      default: begin
        prod_nxt = prod_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    base_r <= base_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    q_r    <= q_nxt;
    neg_r  <= neg_nxt;
    sat_r  <= sat_nxt;
  end

  // clamp to the byte range
  assign quot = q_r;
  assign chan = neg_r ? 8'h00 : (sat_r ? 8'hFF : q_r[7:0]);

endmodule

`default_nettype wire

// ===== rtl/led_gradient_wave.sv =====
// top level of the two-color gradient wave for one led zone
// A pixel word (op 0) steps through fold, multiply, sum, divider load,
// divide and emit; a tick word (op 1) through fold, divider load, divide
// and progress update. No new word is taken before the last is done. The
// restoring divider in each color lane produces one quotient bit per cycle:
// 8 bits per pixel, 24 bits for the progress increment of a tick. A finished
// color sits in the output register while the next word is accepted; the
// sequencer stalls only if a second color is ready before the first is taken.
// Configuration writes take effect at once and must be made while idle.
`default_nettype none

module led_gradient_wave
  import lgw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire lgw_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output lgw_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);

  logic [23:0]        start_color_r, end_color_r;
  logic [LEN_W-1:0]   zone_length_r;
  logic               reverse_r, matrix_mode_r;
  logic [4:0]         speed_r;
  logic [7:0]         frame_rate_r;
  logic [PROG_W-1:0]  prog_r, prog_nxt;
  logic               op_r;
  logic [POS_W-1:0]   pos_r;
  logic [GDIST_W-1:0] gdist_r, gdist_nxt;
  logic               out_valid_r, out_valid_nxt;
  lgw_out_t           out_data_r, out_data_nxt;
  lgw_ctrl_t          ctrl;
  logic               in_fire, out_busy, emit_fire;
  logic [LEN_W-1:0]   len;
  logic [7:0]         fps;
  logic [DIVD_W-1:0]  tick_dividend;
  logic [DIVS_W-1:0]  tick_divisor;
  logic [15:0]        len_speed;
  logic [DIVD_W-1:0]  quot0;
  logic [7:0]         red, green, blue;
  logic [GDIST_W-1:0] s_sum;
  logic [GDIST_W-1:0] lf, lf2;
  logic [PROG_W+3:0]  prog_sum;
  logic [POS_W-1:0]   idx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_color_r <= '0;
      end_color_r   <= '0;
      zone_length_r <= 11'd1;
      reverse_r     <= 1'b0;
      matrix_mode_r <= 1'b0;
      speed_r       <= 5'd10;
      frame_rate_r  <= 8'd60;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_COLOR: start_color_r <= cfg_wdata;
        REG_END_COLOR:   end_color_r   <= cfg_wdata;
        REG_ZONE_LENGTH: zone_length_r <= cfg_wdata[LEN_W-1:0];
        REG_REVERSE:     reverse_r     <= cfg_wdata[0];
        REG_MATRIX_MODE: matrix_mode_r <= cfg_wdata[0];
        REG_SPEED:       speed_r       <= cfg_wdata[4:0];
        REG_FRAME_RATE:  frame_rate_r  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // effective length and frame rate
  always_comb begin
    if (zone_length_r == '0) begin
      len = 11'd1;
    end else if (zone_length_r > MAX_LEDS) begin
      len = MAX_LEDS;
    end else begin
      len = zone_length_r;
    end
  end
  assign fps = (frame_rate_r == '0) ? 8'd1 : frame_rate_r;

  // tick increment operands
  assign len_speed     = len * speed_r;
  assign tick_dividend = matrix_mode_r ? {11'b0, speed_r, 8'b0} : {len_speed, 8'b0};
  assign tick_divisor  = matrix_mode_r ? {4'b0, fps} : ({4'b0, fps} * 12'd10);

  // handshakes
  assign in_ready  = (ctrl.act == ACT_WAIT);
  assign in_fire   = in_valid && in_ready;
  assign out_busy  = out_valid_r && !out_ready;
  assign emit_fire = (ctrl.act == ACT_EMIT) && !out_busy;

  lgw_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .op_tick  (op_r == OP_TICK),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  // folded distance from the wave front
  assign lf    = {3'b0, len, 8'b0};
  assign lf2   = {2'b0, len, 9'b0};
  assign s_sum = {1'b0, prog_r} + {4'b0, pos_r, 8'b0};
  always_comb begin
    gdist_nxt = gdist_r;
    if (ctrl.act == ACT_GFOLD) begin
      if (s_sum <= lf) begin
        gdist_nxt = s_sum;
      end else if (s_sum <= lf2) begin
        gdist_nxt = lf2 - s_sum;
      end else begin
        gdist_nxt = s_sum - lf2;
      end
    end
  end

  // progress update at the end of a tick
  assign prog_sum = {4'b0, prog_r} + {1'b0, quot0};
  always_comb begin
    prog_nxt = prog_r;
    if (ctrl.act == ACT_PUPDATE) begin
      if ({1'b0, prog_r} < lf2) begin
        prog_nxt = (|prog_sum[PROG_W+3:PROG_W]) ? '1 : prog_sum[PROG_W-1:0];
      end else begin
        prog_nxt = '0;
      end
    end
  end

  // captured word and folded distance
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_data.op;
      pos_r <= in_data.position;
    end
    gdist_r <= gdist_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r <= '0;
    end else begin
      prog_r <= prog_nxt;
    end
  end

  lgw_lane u_lane_red (
    .clk           (clk),
    .ctrl          (ctrl),
    .start_ch      (start_color_r[7:0]),
    .end_ch        (end_color_r[7:0]),
    .len           (len),
    .gdist         (gdist_r),
    .tick_dividend (tick_dividend),
    .tick_divisor  (tick_divisor),
    .quot          (quot0),
    .chan          (red)
  );

  lgw_lane u_lane_green (
    .clk           (clk),
    .ctrl          (ctrl),
    .start_ch      (start_color_r[15:8]),
    .end_ch        (end_color_r[15:8]),
    .len           (len),
    .gdist         (gdist_r),
    .tick_dividend (tick_dividend),
    .tick_divisor  (tick_divisor),
    .quot          (),
    .chan          (green)
  );

  lgw_lane u_lane_blue (
    .clk           (clk),
    .ctrl          (ctrl),
    .start_ch      (start_color_r[23:16]),
    .end_ch        (end_color_r[23:16]),
    .len           (len),
    .gdist         (gdist_r),
    .tick_dividend (tick_dividend),
    .tick_divisor  (tick_divisor),
    .quot          (),
    .chan          (blue)
  );

  // output register
  assign idx = reverse_r ? (len[POS_W-1:0] - 10'd1 - pos_r) : pos_r;
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit_fire) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_index = idx;
      out_data_nxt.red       = red;
      out_data_nxt.green     = green;
      out_data_nxt.blue      = blue;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
